/* rtl/bfa_pkg.sv */
// Shared types and codes for the best-fit block heap allocator.
// No dependencies; imported by the allocator core.
package bfa_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_MISALIGN  = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } t_status;

    // request modes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int OFFSET_W = 16;

endpackage

/* rtl/best_fit_block_heap_allocator_core.sv */
// Best-fit heap allocator core: header memory, chain walker and split/merge writer.
// Depends on bfa_pkg (status codes, mode codes).
//
// An allocate walks the chain for the best fit, then writes any remainder
// part and marks the chosen part; with no fit it ends after the walk. A free
// walks the chain to its part, clears the mark, then walks from the start to
// merge the first pair of neighboring free parts, and the part after them if
// free; a part not allocated ends it after the first walk. Rejected requests go
// straight to the result; a full output register holds the result back. The
// single-port header memory reads one header per cycle, so one request is in
// flight at a time, and the next one is accepted from the cycle its result
// appears. Synchronous reset sets the heap to 1024 blocks (or HEAP_BLOCKS if
// smaller) and writes the first header in S_FORMAT; a size write does the same.
module best_fit_block_heap_allocator_core
    import bfa_pkg::*;
#(
    parameter int HEAP_BLOCKS = 1024,
    parameter int BLOCK_BYTES = 8      // power of two
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic [19:0]         i_request_bytes,
    input  logic [15:0]         i_release_offset,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [15:0]         o_granted_offset,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [10:0]         i_cfg_heap_size_blocks
);

    localparam int AW       = (HEAP_BLOCKS > 1) ? $clog2(HEAP_BLOCKS) : 1;
    localparam int SW       = $clog2(HEAP_BLOCKS + 1);
    localparam int LG       = $clog2(BLOCK_BYTES);
    localparam int RST_SIZE = (HEAP_BLOCKS < 1024) ? HEAP_BLOCKS : 1024;

    typedef struct packed {
        logic          alloc;
        logic [SW-1:0] next;
        logic [SW-1:0] len;
    } t_hdr;

    typedef enum logic [10:0] {
        S_FORMAT = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_AWALK  = 11'b000_0000_0100,
        S_ASPLIT = 11'b000_0000_1000,
        S_AMARK  = 11'b000_0001_0000,
        S_FWALK  = 11'b000_0010_0000,
        S_FMARK  = 11'b000_0100_0000,
        S_MSTART = 11'b000_1000_0000,
        S_MWALK  = 11'b001_0000_0000,
        S_MERGE2 = 11'b010_0000_0000,
        S_RESP   = 11'b100_0000_0000
    } t_state;

    // header memory
    t_hdr          mem [HEAP_BLOCKS];
    t_hdr          r_rd;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    t_hdr          mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= mem[mem_ra];
    end

    t_state        r_state, n_state;
    logic [SW-1:0] r_size, n_size;
    logic [AW-1:0] r_a, n_a;
    logic [SW-1:0] r_steps, n_steps;
    logic [SW-1:0] r_need, n_need;
    logic [AW-1:0] r_best, n_best;
    logic [SW-1:0] r_best_len, n_best_len;
    logic [SW-1:0] r_best_next, n_best_next;
    logic          r_have_best, n_have_best;
    logic          r_split, n_split;
    logic [AW-1:0] r_hdr, n_hdr;
    t_hdr          r_ent, n_ent;
    logic [AW-1:0] r_prev, n_prev;
    logic          r_prev_free, n_prev_free;
    logic [SW-1:0] r_prev_len, n_prev_len;
    logic [SW-1:0] r_mnext, n_mnext;
    logic [SW-1:0] r_mlen, n_mlen;
    t_status       r_res_status, n_res_status;
    logic [15:0]   r_res_off, n_res_off;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic [15:0]   r_out_off, n_out_off;

    // walk helpers
    logic [SW:0]   steps_inc;
    logic          walk_cont;
    logic [31:0]   cfg_v, need32, rsum, blk32;
    logic [15:0]   blk;

    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_granted_offset = r_out_off;

    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_a          = r_a;
        n_steps      = r_steps;
        n_need       = r_need;
        n_best       = r_best;
        n_best_len   = r_best_len;
        n_best_next  = r_best_next;
        n_have_best  = r_have_best;
        n_split      = r_split;
        n_hdr        = r_hdr;
        n_ent        = r_ent;
        n_prev       = r_prev;
        n_prev_free  = r_prev_free;
        n_prev_len   = r_prev_len;
        n_mnext      = r_mnext;
        n_mlen       = r_mlen;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_off    = r_out_off;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;

        steps_inc = {1'b0, r_steps} + 1'b1;
        walk_cont = ({1'b0, r_rd.next} < {1'b0, r_size}) && (steps_inc < {1'b0, r_size});
        cfg_v  = 32'(i_cfg_heap_size_blocks);
        need32 = 32'(i_request_bytes >> LG) + 32'(|i_request_bytes[LG-1:0]) + 32'd1;
        rsum   = 32'(r_best) + 32'(r_need);
        blk    = i_release_offset >> LG;
        blk32  = 32'(blk);

        case (r_state)
            // write the single free part covering the heap
            S_FORMAT: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = '{alloc: 1'b0, next: r_size, len: r_size};
                n_state = S_IDLE;
            end

            S_IDLE: begin
                if (i_cfg_valid) begin
                    if (cfg_v < 32'd2) cfg_v = 32'd2;
                    if (cfg_v > 32'(HEAP_BLOCKS)) cfg_v = 32'(HEAP_BLOCKS);
                    n_size  = SW'(cfg_v);
                    n_state = S_FORMAT;
                end else if (i_valid) begin
                    n_a         = '0;
                    n_steps     = '0;
                    n_have_best = 1'b0;
                    n_prev_free = 1'b0;
                    n_res_off   = '0;
                    if (i_mode == OP_ALLOC) begin
                        if (i_request_bytes == '0 || need32 > 32'(r_size)) begin
                            n_res_status = ST_NO_FIT;
                            n_state      = S_RESP;
                        end else begin
                            n_need  = SW'(need32);
                            mem_re  = 1'b1;
                            n_state = S_AWALK;
                        end
                    end else begin
                        if (|i_release_offset[LG-1:0]) begin
                            n_res_status = ST_MISALIGN;
                            n_state      = S_RESP;
                        end else if (blk32 > 32'(r_size)) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RESP;
                        end else if (blk == '0) begin
                            n_res_status = ST_NOT_ALLOC;
                            n_state      = S_RESP;
                        end else begin
                            n_hdr   = AW'(blk32 - 32'd1);
                            mem_re  = 1'b1;
                            n_state = S_FWALK;
                        end
                    end
                end
            end

            // best-fit search, one header per cycle
            S_AWALK: begin
                if (!r_rd.alloc && r_rd.len >= r_need &&
                    (!r_have_best || r_rd.len < r_best_len)) begin
                    n_best      = r_a;
                    n_best_len  = r_rd.len;
                    n_best_next = r_rd.next;
                    n_have_best = 1'b1;
                end
                n_steps = SW'(steps_inc);
                if (walk_cont) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_rd.next[AW-1:0];
                    n_a     = r_rd.next[AW-1:0];
                end else begin
                    n_state = S_ASPLIT;
                end
            end

            // write the remainder part when there is one
            S_ASPLIT: begin
                if (!r_have_best) begin
                    n_res_status = ST_NO_FIT;
                    n_state      = S_RESP;
                end else begin
                    n_split = (r_best_len > r_need) && (rsum < 32'(r_size));
                    if (n_split) begin
                        mem_we = 1'b1;
                        mem_wa = AW'(rsum);
                        mem_wd = '{alloc: 1'b0, next: r_best_next, len: r_best_len - r_need};
                    end
                    n_state = S_AMARK;
                end
            end

            S_AMARK: begin
                mem_we = 1'b1;
                mem_wa = r_best;
                mem_wd = '{alloc: 1'b1,
                           next:  r_split ? SW'(rsum) : r_best_next,
                           len:   r_split ? r_need : r_best_len};
                n_res_status = ST_OK;
                n_res_off    = 16'((32'(r_best) + 32'd1) << LG);
                n_state      = S_RESP;
            end

            // look for the allocated part at the header block
            S_FWALK: begin
                n_steps = SW'(steps_inc);
                if (r_rd.alloc && r_a == r_hdr) begin
                    n_ent   = r_rd;
                    n_state = S_FMARK;
                end else if (walk_cont) begin
                    mem_re = 1'b1;
                    mem_ra = r_rd.next[AW-1:0];
                    n_a    = r_rd.next[AW-1:0];
                end else begin
                    n_res_status = ST_NOT_ALLOC;
                    n_state      = S_RESP;
                end
            end

            S_FMARK: begin
                mem_we  = 1'b1;
                mem_wa  = r_hdr;
                mem_wd  = '{alloc: 1'b0, next: r_ent.next, len: r_ent.len};
                n_state = S_MSTART;
            end

            // read after the mark write has landed
            S_MSTART: begin
                mem_re       = 1'b1;
                n_a          = '0;
                n_steps      = '0;
                n_prev_free  = 1'b0;
                n_res_status = ST_OK;
                n_state      = S_MWALK;
            end

            // find the first pair of neighboring free parts
            S_MWALK: begin
                n_steps = SW'(steps_inc);
                if (!r_rd.alloc && r_prev_free) begin
                    n_mnext = r_rd.next;
                    n_mlen  = r_prev_len + r_rd.len;
                    if ({1'b0, r_rd.next} < {1'b0, r_size}) begin
                        mem_re  = 1'b1;
                        mem_ra  = r_rd.next[AW-1:0];
                        n_state = S_MERGE2;
                    end else begin
                        mem_we  = 1'b1;
                        mem_wa  = r_prev;
                        mem_wd  = '{alloc: 1'b0, next: r_rd.next, len: r_prev_len + r_rd.len};
                        n_state = S_RESP;
                    end
                end else begin
                    n_prev_free = !r_rd.alloc;
                    n_prev      = r_a;
                    n_prev_len  = r_rd.len;
                    if (walk_cont) begin
                        mem_re = 1'b1;
                        mem_ra = r_rd.next[AW-1:0];
                        n_a    = r_rd.next[AW-1:0];
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end

            // merge the next part too when it is free, then write the merged header
            S_MERGE2: begin
                mem_we = 1'b1;
                mem_wa = r_prev;
                if (!r_rd.alloc) begin
                    mem_wd = '{alloc: 1'b0, next: r_rd.next, len: r_mlen + r_rd.len};
                end else begin
                    mem_wd = '{alloc: 1'b0, next: r_mnext, len: r_mlen};
                end
                n_state = S_RESP;
            end

            // hand the result to the output register once it is free
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_off    = (r_res_status == ST_OK) ? r_res_off : '0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FORMAT;
            r_size      <= SW'(RST_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
        r_a          <= n_a;
        r_steps      <= n_steps;
        r_need       <= n_need;
        r_best       <= n_best;
        r_best_len   <= n_best_len;
        r_best_next  <= n_best_next;
        r_have_best  <= n_have_best;
        r_split      <= n_split;
        r_hdr        <= n_hdr;
        r_ent        <= n_ent;
        r_prev       <= n_prev;
        r_prev_free  <= n_prev_free;
        r_prev_len   <= n_prev_len;
        r_mnext      <= n_mnext;
        r_mlen       <= n_mlen;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_out_status <= n_out_status;
        r_out_off    <= n_out_off;
    end

    // a failed request never carries an offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_granted_offset == '0))
        else $error("offset on failed result");

    // writes and reads of the header memory never share a cycle
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("header memory read and write overlap");

    // an accepted beat closes the input until its result is out
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item accepted while busy");

    // no header write while the block claims to be idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !mem_we)
        else $error("header write while idle");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for best_fit_block_heap_allocator_core.
// Depends on bfa_pkg and the core RTL; alloc/free requests are checked against an in-bench heap model.
`timescale 1ns / 1ps

module testbench
    import bfa_pkg::*;
();

    localparam int HEAP_MAX = 1024;
    localparam int BLK_BYTES = 8;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] offset;
    } t_grant;

    typedef struct packed {
        logic        mode;
        logic [19:0] bytes;
        logic [15:0] off;
    } t_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [19:0] i_request_bytes;
    logic [15:0] i_release_offset;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [15:0] o_granted_offset;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_heap_size_blocks;

    best_fit_block_heap_allocator_core i_dut (.*);

    // heap shadow
    int          heap_blocks;
    bit          hdr_alloc [HEAP_MAX];
    int          hdr_next  [HEAP_MAX];
    int          hdr_len   [HEAP_MAX];
    t_grant      grant_q[$];
    int          live_offs[$];
    int          errors;
    int          cycles;
    bit          hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void format_heap(input int v);
        if (v < 2) v = 2;
        if (v > HEAP_MAX) v = HEAP_MAX;
        heap_blocks = v;
        hdr_alloc[0] = 1'b0;
        hdr_next[0] = v;
        hdr_len[0] = v;
    endfunction

    function automatic void merge_next(input int a);
        int nx;
        nx = hdr_next[a];
        if (nx >= heap_blocks) return;
        if (hdr_alloc[a] || hdr_alloc[nx]) return;
        hdr_next[a] = hdr_next[nx];
        hdr_len[a] = (hdr_len[a] + hdr_len[nx]) & 16'hFFFF;
    endfunction

    function automatic t_grant heap_alloc(input int bytes);
        t_grant g;
        int need, a, steps, best, best_len, r;
        g = '0;
        g.status = ST_NO_FIT;
        if (bytes == 0) return g;
        need = (bytes + BLK_BYTES - 1) / BLK_BYTES + 1;
        if (need > heap_blocks) return g;
        best = -1;
        best_len = 32'h7FFFFFFF;
        a = 0;
        steps = 0;
        while (a < heap_blocks && steps < heap_blocks) begin
            steps++;
            if (!hdr_alloc[a] && hdr_len[a] >= need && hdr_len[a] < best_len) begin
                best = a;
                best_len = hdr_len[a];
            end
            a = hdr_next[a];
        end
        if (best < 0) return g;
        if (best_len > need) begin
            r = best + need;
            if (r < heap_blocks) begin
                hdr_alloc[r] = 1'b0;
                hdr_len[r] = best_len - need;
                hdr_next[r] = hdr_next[best];
                hdr_next[best] = r;
                hdr_len[best] = need;
            end
        end
        hdr_alloc[best] = 1'b1;
        g.status = ST_OK;
        g.offset = 16'(((best + 1) * BLK_BYTES));
        return g;
    endfunction

    function automatic t_grant heap_free(input int off);
        t_grant g;
        int blk, hdr, a, steps, prev;
        bit found, prev_free, is_free;
        g = '0;
        found = 0;
        prev_free = 0;
        if (off % BLK_BYTES) begin
            g.status = ST_MISALIGN;
            return g;
        end
        blk = off / BLK_BYTES;
        if (blk > heap_blocks) begin
            g.status = ST_RANGE;
            return g;
        end
        g.status = ST_NOT_ALLOC;
        if (blk == 0) return g;
        hdr = blk - 1;
        a = 0;
        steps = 0;
        while (a < heap_blocks && steps < heap_blocks) begin
            steps++;
            if (hdr_alloc[a] && a == hdr) begin
                found = 1;
                break;
            end
            a = hdr_next[a];
        end
        if (!found) return g;
        hdr_alloc[hdr] = 1'b0;
        a = 0;
        steps = 0;
        prev = 0;
        while (a < heap_blocks && steps < heap_blocks) begin
            is_free = !hdr_alloc[a];
            steps++;
            if (is_free && prev_free) begin
                merge_next(prev);
                merge_next(prev);
                break;
            end
            prev_free = is_free;
            prev = a;
            a = hdr_next[a];
        end
        g.status = ST_OK;
        return g;
    endfunction

    // short gap, occasionally long; valid drops only when there is a gap
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n != 0) i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // send one beat and leave valid up; predicted result queued (or a typed one if given)
    task automatic send_req(input t_req rq, input bit typed, input t_grant want);
        t_grant g;
        i_valid <= 1'b1;
        i_mode <= rq.mode;
        i_request_bytes <= rq.bytes;
        i_release_offset <= rq.off;
        do @(posedge i_clk); while (!o_ready);
        if (rq.mode == OP_ALLOC) g = heap_alloc(int'(rq.bytes));
        else g = heap_free(int'(rq.off));
        if (g.status == ST_OK && rq.mode == OP_ALLOC) live_offs.push_back(int'(g.offset));
        if (typed && g != want) begin
            $display("%0t predictor disagrees with table: exp %p got %p", $time, want, g);
            errors++;
        end
        grant_q.push_back(typed ? want : g);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (HEAP_MAX * 3) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [10:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_heap_size_blocks <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        format_heap(int'(v));
        live_offs.delete();
    endtask

    function automatic t_req rand_req();
        t_req rq;
        int k, pick;
        rq.bytes = 20'($urandom);
        rq.off = 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 45) begin
            rq.mode = OP_ALLOC;
            rq.bytes = (k < 40) ? 20'($urandom_range(1, 64)) : 20'($urandom);
        end else if (k < 85 && live_offs.size() != 0) begin
            rq.mode = OP_FREE;
            pick = $urandom_range(0, live_offs.size() - 1);
            rq.off = 16'(live_offs[pick]);
            live_offs.delete(pick);
        end else begin
            rq.mode = OP_FREE;
            if (k < 92) rq.off = 16'($urandom_range(0, heap_blocks + 2) * BLK_BYTES);
        end
        return rq;
    endfunction

    // result checker with random stalls and one long hold-off
    initial begin
        t_grant e;
        int n;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (grant_q.size() == 0) begin
                    $display("%0t unexpected result: status %0d offset %0d",
                             $time, o_status, o_granted_offset);
                    errors++;
                end else begin
                    e = grant_q.pop_front();
                    if (o_status !== e.status) begin
                        $display("%0t status mismatch: exp %0d got %0d",
                                 $time, e.status, o_status);
                        errors++;
                    end
                    if (o_granted_offset !== e.offset) begin
                        $display("%0t offset mismatch: exp %0d got %0d",
                                 $time, e.offset, o_granted_offset);
                        errors++;
                    end
                end
            end
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
                i_ready <= 1'b1;
            end else begin
                n = $urandom_range(0, 9);
                i_ready <= (n < 6) || (n == 9 && cycles[10]);
            end
        end
    end

    t_req   dir_req [20];
    bit     dir_typed [20];
    t_grant dir_want [20];

    initial begin
        t_req rq;
        t_grant w;
        logic [10:0] sizes [5];
        cycles = 0;
        errors = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = OP_ALLOC;
        i_request_bytes = '0;
        i_release_offset = '0;
        i_cfg_valid = 1'b0;
        i_cfg_heap_size_blocks = '0;
        format_heap(1024);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: {mode, bytes, offset}, typed where obvious
        dir_req[0]  = {OP_ALLOC, 20'd0, 16'd0};      dir_typed[0] = 1;
        dir_want[0] = {ST_NO_FIT, 16'd0};
        dir_req[1]  = {OP_ALLOC, 20'hFFFFF, 16'hFFFF}; dir_typed[1] = 1;
        dir_want[1] = {ST_NO_FIT, 16'd0};
        dir_req[2]  = {OP_ALLOC, 20'd1, 16'd0};      dir_typed[2] = 1;
        dir_want[2] = {ST_OK, 16'd8};
        dir_req[3]  = {OP_FREE, 20'd0, 16'd3};       dir_typed[3] = 1;
        dir_want[3] = {ST_MISALIGN, 16'd0};
        dir_req[4]  = {OP_FREE, 20'hFFFFF, 16'hFFF8}; dir_typed[4] = 1;
        dir_want[4] = {ST_RANGE, 16'd0};
        dir_req[5]  = {OP_FREE, 20'd0, 16'd0};       dir_typed[5] = 1;
        dir_want[5] = {ST_NOT_ALLOC, 16'd0};
        dir_req[6]  = {OP_FREE, 20'd0, 16'd64};      dir_typed[6] = 1;
        dir_want[6] = {ST_NOT_ALLOC, 16'd0};
        dir_req[7]  = {OP_ALLOC, 20'd8, 16'd0};      dir_typed[7] = 1;
        dir_want[7] = {ST_OK, 16'd24};
        dir_req[8]  = {OP_ALLOC, 20'd9, 16'd0};      dir_typed[8] = 0;
        dir_req[9]  = {OP_FREE, 20'd0, 16'd8};       dir_typed[9] = 0;
        dir_req[10] = {OP_FREE, 20'd0, 16'd24};      dir_typed[10] = 0;
        dir_req[11] = {OP_ALLOC, 20'd8184, 16'd0};   dir_typed[11] = 0;
        dir_req[12] = {OP_ALLOC, 20'd8185, 16'd0};   dir_typed[12] = 0;
        dir_req[13] = {OP_FREE, 20'd0, 16'd8192};    dir_typed[13] = 0;
        dir_req[14] = {OP_FREE, 20'd0, 16'd8200};    dir_typed[14] = 0;
        dir_req[15] = {OP_ALLOC, 20'd100, 16'd0};    dir_typed[15] = 0;
        dir_req[16] = {OP_ALLOC, 20'd100, 16'd0};    dir_typed[16] = 0;
        dir_req[17] = {OP_FREE, 20'd0, 16'd104};     dir_typed[17] = 0;
        dir_req[18] = {OP_ALLOC, 20'd16, 16'd0};     dir_typed[18] = 0;
        dir_req[19] = {OP_FREE, 20'd0, 16'd24};      dir_typed[19] = 0;
        for (int i = 0; i < 20; i++) begin
            send_req(dir_req[i], dir_typed[i], dir_want[i]);
            idle_gap();
        end
        drain();

        // random phases over several heap sizes, extremes included
        sizes[0] = 11'd2;    sizes[1] = 11'd0;  sizes[2] = 11'd2047;
        sizes[3] = 11'd37;   sizes[4] = 11'd1024;
        for (int p = 0; p < 5; p++) begin
            write_size(sizes[p]);
            for (int i = 0; i < 206; i++) begin
                rq = rand_req();
                // long receiver hold-off while requests keep coming
                if (p == 1 && i == 10) hold_off = 1;
                send_req(rq, 0, w);
                // sender pause until all results are back
                if (p == 3 && i == 100) begin
                    i_valid <= 1'b0;
                    while (grant_q.size() != 0) @(posedge i_clk);
                end else if (!(p == 1 && i < 40)) idle_gap();
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
